/* src/bf_pkg.sv */
package bf_pkg;

  localparam int SIDE_W = 11;
  localparam int PIX_W  = 16;
  localparam int POS_W  = 10;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd1024;

  localparam int NRES    = 4;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  // result slots of one input, in emission order
  typedef enum logic [1:0] {
    RES_A_LEFT,
    RES_A_EDGE,
    RES_B_LEFT,
    RES_B_EDGE
  } res_kind_t;

  typedef struct packed {
    logic [NRES-1:0] mask;
    logic            r_ge1;
    logic            r_ge2;
    logic            c_ge1;
    logic            c_ge2;
  } run_ctl_t;

endpackage

/* src/bf_if.sv */
interface bf_pix_if;
  logic                      valid;
  logic                      ready;
  logic [bf_pkg::PIX_W-1:0]  in_red;
  logic [bf_pkg::PIX_W-1:0]  in_green;
  logic [bf_pkg::PIX_W-1:0]  in_blue;

  modport source (output valid, in_red, in_green, in_blue, input ready);
  modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface bf_res_if;
  logic                      valid;
  logic                      ready;
  logic [bf_pkg::PIX_W-1:0]  out_red;
  logic [bf_pkg::PIX_W-1:0]  out_green;
  logic [bf_pkg::PIX_W-1:0]  out_blue;
  logic [bf_pkg::POS_W-1:0]  out_row;
  logic [bf_pkg::POS_W-1:0]  out_col;
  logic                      last_in_run;

  modport source (output valid, out_red, out_green, out_blue, out_row, out_col, last_in_run,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_row, out_col, last_in_run,
                output ready);
endinterface

/* src/bf_linebuf.sv */
module bf_linebuf #(
  parameter int DEPTH = 1024,
  parameter int DW    = 96
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/bf_window.sv */
module bf_window #(
  parameter int MAX_SIDE     = 1024,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_we,
  input  logic [bf_pkg::SIDE_W-1:0]                   cfg_data,
  input  logic                                        accept,
  input  logic [2:0][CHANNEL_BITS-1:0]                pix,
  output logic                                        mem_rd_en,
  output logic [$clog2(MAX_SIDE)-1:0]                 mem_rd_addr,
  input  logic [6*CHANNEL_BITS-1:0]                   mem_rd_data,
  output logic                                        mem_wr_en,
  output logic [$clog2(MAX_SIDE)-1:0]                 mem_wr_addr,
  output logic [6*CHANNEL_BITS-1:0]                   mem_wr_data,
  output logic                                        busy,
  output logic                                        push,
  output bf_pkg::run_ctl_t                            push_ctl,
  output logic [$clog2(MAX_SIDE)-1:0]                 push_row,
  output logic [$clog2(MAX_SIDE)-1:0]                 push_col,
  output logic [2:0][2:0][CHANNEL_BITS+1:0]           push_wa,
  output logic [2:0][2:0][CHANNEL_BITS+1:0]           push_wb
);
  import bf_pkg::*;

  localparam int CW   = $clog2(MAX_SIDE);
  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int PW   = 3 * CHANNEL_BITS;
  localparam int COLW = CHANNEL_BITS + 2;

  logic [SIDE_W-1:0] side_reg;
  logic [SW-1:0]     side_eff;
  logic [CW-1:0]     last_idx;
  logic [CW-1:0]     row;
  logic [CW-1:0]     col;

  logic                         s1_valid;
  logic [2:0][CHANNEL_BITS-1:0] s1_p;
  logic [CW-1:0]                s1_r;
  logic [CW-1:0]                s1_c;
  logic                         s1_r_ge1, s1_r_ge2, s1_c_ge1, s1_c_ge2;
  logic                         s1_last_row, s1_last_col;

  logic [2:0][COLW-1:0] wa [3];
  logic [2:0][COLW-1:0] wb [3];
  logic [2:0][COLW-1:0] col_a, col_b;
  logic [PW-1:0]        newer, older;

  always_comb begin
    if (side_reg == '0) begin
      side_eff = SW'(1);
    end else if (32'(side_reg) > 32'(MAX_SIDE)) begin
      side_eff = SW'(MAX_SIDE);
    end else begin
      side_eff = SW'(side_reg);
    end
    last_idx = CW'(side_eff - SW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_reg <= SIDE_RESET;
      row      <= '0;
      col      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (cfg_we) begin
        side_reg <= cfg_data;
        row      <= '0;
        col      <= '0;
      end else if (accept) begin
        if (col == last_idx) begin
          col <= '0;
          row <= (row == last_idx) ? '0 : row + CW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_p        <= pix;
      s1_r        <= row;
      s1_c        <= col;
      s1_r_ge1    <= row != '0;
      s1_r_ge2    <= row != '0 && row != CW'(1);
      s1_c_ge1    <= col != '0;
      s1_c_ge2    <= col != '0 && col != CW'(1);
      s1_last_row <= row == last_idx;
      s1_last_col <= col == last_idx;
    end
  end

  // entry holds {row r-1, row r-2}; only a side of one reads and writes one
  // entry in adjacent cycles, and then the rows above are never used
  assign mem_rd_en   = accept;
  assign mem_rd_addr = col;
  assign newer       = mem_rd_data[2*PW-1:PW];
  assign older       = mem_rd_data[PW-1:0];
  assign mem_wr_en   = s1_valid;
  assign mem_wr_addr = s1_c;
  assign mem_wr_data = {s1_p, newer};
  assign busy        = s1_valid;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [COLW-1:0] up, up2;
      up  = s1_r_ge1 ? COLW'(newer[ch*CHANNEL_BITS +: CHANNEL_BITS]) : '0;
      up2 = s1_r_ge2 ? COLW'(older[ch*CHANNEL_BITS +: CHANNEL_BITS]) : '0;
      col_b[ch] = COLW'(s1_p[ch]) + up;
      col_a[ch] = col_b[ch] + up2;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      wa[0] <= wa[1];
      wa[1] <= wa[2];
      wa[2] <= col_a;
      wb[0] <= wb[1];
      wb[1] <= wb[2];
      wb[2] <= col_b;
    end
  end

  always_comb begin
    push_ctl.mask[RES_A_LEFT] = s1_r_ge1 && s1_c_ge1;
    push_ctl.mask[RES_A_EDGE] = s1_r_ge1 && s1_last_col;
    push_ctl.mask[RES_B_LEFT] = s1_last_row && s1_c_ge1;
    push_ctl.mask[RES_B_EDGE] = s1_last_row && s1_last_col;
    push_ctl.r_ge1 = s1_r_ge1;
    push_ctl.r_ge2 = s1_r_ge2;
    push_ctl.c_ge1 = s1_c_ge1;
    push_ctl.c_ge2 = s1_c_ge2;
    push     = s1_valid && (push_ctl.mask != '0);
    push_row = s1_r;
    push_col = s1_c;
    push_wa  = {col_a, wa[2], wa[1]};
    push_wb  = {col_b, wb[2], wb[1]};
  end

endmodule

/* src/bf_mean.sv */
module bf_mean #(
  parameter int MAX_SIDE     = 1024,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  bf_pkg::run_ctl_t                  push_ctl,
  input  logic [$clog2(MAX_SIDE)-1:0]       push_row,
  input  logic [$clog2(MAX_SIDE)-1:0]       push_col,
  input  logic [2:0][2:0][CHANNEL_BITS+1:0] push_wa,
  input  logic [2:0][2:0][CHANNEL_BITS+1:0] push_wb,
  output logic [bf_pkg::Q_CW-1:0]           level,
  bf_res_if.source                          res
);
  import bf_pkg::*;

  localparam int CW   = $clog2(MAX_SIDE);
  localparam int COLW = CHANNEL_BITS + 2;
  localparam int SUMW = CHANNEL_BITS + 4;
  localparam int SH   = SUMW + 4;
  localparam int RW   = SH + 1;
  localparam int PRW  = SUMW + RW;
  localparam longint unsigned ONE = 64'd1 << SH;
  localparam logic [RW-1:0] M1 = RW'(ONE);
  localparam logic [RW-1:0] M2 = RW'((ONE + 1) / 2);
  localparam logic [RW-1:0] M3 = RW'((ONE + 2) / 3);
  localparam logic [RW-1:0] M4 = RW'((ONE + 3) / 4);
  localparam logic [RW-1:0] M6 = RW'((ONE + 5) / 6);
  localparam logic [RW-1:0] M9 = RW'((ONE + 8) / 9);

  run_ctl_t                  q_ctl [Q_DEPTH];
  logic [CW-1:0]             q_row [Q_DEPTH];
  logic [CW-1:0]             q_col [Q_DEPTH];
  logic [2:0][2:0][COLW-1:0] q_wa  [Q_DEPTH];
  logic [2:0][2:0][COLW-1:0] q_wb  [Q_DEPTH];
  logic [Q_AW-1:0]           wr_ptr, rd_ptr;
  logic [Q_CW-1:0]           count;

  logic            rem_valid;
  logic [NRES-1:0] rem, cur, new_rem;
  res_kind_t       kind;
  logic            out_en, x_en, issue, pop;

  logic                      sel_b, is_edge, use0, use1;
  logic [1:0]                rows, ncols;
  logic [3:0]                divisor;
  logic [RW-1:0]             recip;
  logic [2:0][2:0][COLW-1:0] w;
  logic [2:0][SUMW-1:0]      sum;
  logic [CW-1:0]             row_sel, col_sel;

  logic                 x_valid;
  logic [2:0][SUMW-1:0] x_sum;
  logic [RW-1:0]        x_m;
  logic [CW-1:0]        x_row, x_col;
  logic                 x_last;
  logic [2:0][PRW-1:0]  prod;

  run_ctl_t head_ctl;
  assign head_ctl = q_ctl[rd_ptr];

  // pick the next pending result of the head entry, lowest slot first
  always_comb begin
    cur  = rem_valid ? rem : head_ctl.mask;
    kind = RES_B_EDGE;
    priority if (cur[RES_A_LEFT]) kind = RES_A_LEFT;
    else if (cur[RES_A_EDGE])     kind = RES_A_EDGE;
    else if (cur[RES_B_LEFT])     kind = RES_B_LEFT;
    else                          kind = RES_B_EDGE;
    new_rem = cur & ~(NRES'(1) << kind);
  end

  assign out_en = !res.valid || res.ready;
  assign x_en   = !x_valid || out_en;
  assign issue  = (count != '0) && x_en;
  assign pop    = issue && (new_rem == '0);
  assign level  = count;

  always_comb begin
    unique case (kind)
      RES_A_LEFT: begin sel_b = 1'b0; is_edge = 1'b0; end
      RES_A_EDGE: begin sel_b = 1'b0; is_edge = 1'b1; end
      RES_B_LEFT: begin sel_b = 1'b1; is_edge = 1'b0; end
      RES_B_EDGE: begin sel_b = 1'b1; is_edge = 1'b1; end
      default:    begin sel_b = 1'b0; is_edge = 1'b0; end
    endcase
    use0  = !is_edge && head_ctl.c_ge2;
    use1  = is_edge ? head_ctl.c_ge1 : 1'b1;
    ncols = 2'd1 + 2'(use0) + 2'(use1);
    if (sel_b) begin
      rows = head_ctl.r_ge1 ? 2'd2 : 2'd1;
    end else begin
      rows = head_ctl.r_ge2 ? 2'd3 : 2'd2;
    end
    divisor = 4'(rows) * 4'(ncols);
    unique case (divisor)
      4'd1:    recip = M1;
      4'd2:    recip = M2;
      4'd3:    recip = M3;
      4'd4:    recip = M4;
      4'd6:    recip = M6;
      4'd9:    recip = M9;
      default: recip = M1;
    endcase
    w = sel_b ? q_wb[rd_ptr] : q_wa[rd_ptr];
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = (use0 ? SUMW'(w[0][ch]) : '0) + (use1 ? SUMW'(w[1][ch]) : '0)
              + SUMW'(w[2][ch]);
    end
    row_sel = sel_b ? q_row[rd_ptr] : q_row[rd_ptr] - CW'(1);
    col_sel = is_edge ? q_col[rd_ptr] : q_col[rd_ptr] - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      rem_valid <= 1'b0;
      x_valid   <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      count <= count + Q_CW'(push) - Q_CW'(pop);
      if (issue) begin
        rem_valid <= new_rem != '0;
      end
      if (x_en) begin
        x_valid <= issue;
      end
      if (out_en) begin
        res.valid <= x_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_ctl[wr_ptr] <= push_ctl;
      q_row[wr_ptr] <= push_row;
      q_col[wr_ptr] <= push_col;
      q_wa[wr_ptr]  <= push_wa;
      q_wb[wr_ptr]  <= push_wb;
    end
    if (issue) begin
      rem    <= new_rem;
      x_sum  <= sum;
      x_m    <= recip;
      x_row  <= row_sel;
      x_col  <= col_sel;
      x_last <= new_rem == '0;
    end
  end

  // exact floor division by reciprocal for numerators below 2^SUMW
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PRW'(x_sum[ch]) * PRW'(x_m);
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && x_valid) begin
      res.out_red     <= PIX_W'(prod[0] >> SH);
      res.out_green   <= PIX_W'(prod[1] >> SH);
      res.out_blue    <= PIX_W'(prod[2] >> SH);
      res.out_row     <= POS_W'(x_row);
      res.out_col     <= POS_W'(x_col);
      res.last_in_run <= x_last;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < Q_CW'(Q_DEPTH)) || pop)
    else $error("result queue overflow");
  a_partial_needs_entry: assert property (@(posedge clk) disable iff (rst)
    rem_valid |-> count != '0)
    else $error("partial run without a queued entry");
  a_entry_has_result: assert property (@(posedge clk) disable iff (rst)
    (count != '0 && !rem_valid) |-> head_ctl.mask != '0)
    else $error("queued entry carries no result");
`endif

endmodule

/* src/box_filter_3x3_edge_mean_top.sv */
// channel  direction  beat contents
// pix      in         in_red, in_green, in_blue (one raster-order pixel)
// res      out        out_red/green/blue, out_row, out_col, last_in_run
// cfg      in         cfg_we, cfg_data (image side, restarts the frame)
//
// one pixel per cycle while pix.ready is high; a pixel closing a row or on
// the last row yields up to four beats, emitted one per cycle while
// res.ready is high, via the s1 stage, a four-entry run queue, the x stage
// and the output register; the line buffer is one memory, read at accept
// and written back in the following cycle; rst is synchronous; line buffer
// contents are not cleared; pix.ready drops when level+busy reaches Q_DEPTH
module box_filter_3x3_edge_mean_top #(
  parameter int MAX_SIDE     = 1024,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bf_pkg::SIDE_W-1:0] cfg_data,
  bf_pix_if.sink                    pix,
  bf_res_if.source                  res
);
  import bf_pkg::*;

  localparam int CW = $clog2(MAX_SIDE);
  localparam int DW = 6 * CHANNEL_BITS;

  logic                              accept, busy, push;
  logic [2:0][CHANNEL_BITS-1:0]      px;
  logic                              mem_rd_en, mem_wr_en;
  logic [CW-1:0]                     mem_rd_addr, mem_wr_addr;
  logic [DW-1:0]                     mem_rd_data, mem_wr_data;
  run_ctl_t                          push_ctl;
  logic [CW-1:0]                     push_row, push_col;
  logic [2:0][2:0][CHANNEL_BITS+1:0] push_wa, push_wb;
  logic [Q_CW-1:0]                   level;

  assign px[0]     = pix.in_red[CHANNEL_BITS-1:0];
  assign px[1]     = pix.in_green[CHANNEL_BITS-1:0];
  assign px[2]     = pix.in_blue[CHANNEL_BITS-1:0];
  assign pix.ready = (4'(level) + 4'(busy)) < 4'(Q_DEPTH);
  assign accept    = pix.valid && pix.ready;

  bf_linebuf #(.DEPTH(MAX_SIDE), .DW(DW)) u_linebuf (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  bf_window #(.MAX_SIDE(MAX_SIDE), .CHANNEL_BITS(CHANNEL_BITS)) u_window (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .pix         (px),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .busy        (busy),
    .push        (push),
    .push_ctl    (push_ctl),
    .push_row    (push_row),
    .push_col    (push_col),
    .push_wa     (push_wa),
    .push_wb     (push_wb)
  );

  bf_mean #(.MAX_SIDE(MAX_SIDE), .CHANNEL_BITS(CHANNEL_BITS)) u_mean (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ctl (push_ctl),
    .push_row (push_row),
    .push_col (push_col),
    .push_wa  (push_wa),
    .push_wb  (push_wb),
    .level    (level),
    .res      (res)
  );

endmodule

/* tb/sv/box_filter_3x3_edge_mean_top_test.sv */
`timescale 1ns / 1ps

module box_filter_3x3_edge_mean_top_test;
  import bf_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } mean_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [SIDE_W-1:0] cfg_data = '0;

  bf_pix_if pix ();
  bf_res_if res ();

  box_filter_3x3_edge_mean_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data), .pix(pix), .res(res)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [SIDE_W-1:0] side_reg;
  logic [PIX_W-1:0]  prev2_row [0:1023][0:2];
  logic [PIX_W-1:0]  prev1_row [0:1023][0:2];
  int unsigned       col_sums [0:5][0:2];
  int unsigned       cur_row, cur_col;

  pixel_t pixels_pending[$];
  mean_t  means_due[$];
  int     error_count = 0;
  int     beats_checked = 0;
  int     pixels_sent = 0;
  int     cycle_count = 0;
  bit     quiet_stretch = 0;
  bit     hold_pixels = 0;

  function automatic int unsigned clip_side();
    if (side_reg == 0) return 1;
    if (side_reg > 1024) return 1024;
    return side_reg;
  endfunction

  function automatic void emit_mean(int base, int first, int rows, int unsigned row,
                                    int unsigned col);
    mean_t m;
    int unsigned tot [0:2];
    int unsigned n;
    n = rows * (3 - first);
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = 0;
      for (int s = first; s < 3; s++) tot[ch] += col_sums[base + s][ch];
    end
    m.red = tot[0] / n;
    m.green = tot[1] / n;
    m.blue = tot[2] / n;
    m.row = row[POS_W-1:0];
    m.col = col[POS_W-1:0];
    m.last = 1'b0;
    means_due.push_back(m);
  endfunction

  function automatic void predict_pixel(pixel_t p);
    int unsigned s, r, c, pv [0:2], up, up2;
    int n;
    bit last_row, last_col;
    s = clip_side();
    r = cur_row;
    c = cur_col;
    if (r >= s || c >= s) begin
      r = 0;
      c = 0;
    end
    pv[0] = p.red;
    pv[1] = p.green;
    pv[2] = p.blue;
    for (int ch = 0; ch < 3; ch++) begin
      col_sums[0][ch] = col_sums[1][ch];
      col_sums[1][ch] = col_sums[2][ch];
      col_sums[3][ch] = col_sums[4][ch];
      col_sums[4][ch] = col_sums[5][ch];
      up = (r >= 1) ? prev1_row[c][ch] : 0;
      up2 = (r >= 2) ? prev2_row[c][ch] : 0;
      col_sums[2][ch] = pv[ch] + up + up2;
      col_sums[5][ch] = pv[ch] + up;
    end
    last_row = (r == s - 1);
    last_col = (c == s - 1);
    n = means_due.size();
    if (r >= 1 && c >= 1) emit_mean(0, (c >= 2) ? 0 : 1, (r >= 2) ? 3 : 2, r - 1, c - 1);
    if (r >= 1 && last_col) emit_mean(0, (c >= 1) ? 1 : 2, (r >= 2) ? 3 : 2, r - 1, c);
    if (last_row && c >= 1) emit_mean(3, (c >= 2) ? 0 : 1, (r >= 1) ? 2 : 1, r, c - 1);
    if (last_row && last_col) emit_mean(3, (c >= 1) ? 1 : 2, (r >= 1) ? 2 : 1, r, c);
    if (means_due.size() > n) means_due[$].last = 1'b1;
    for (int ch = 0; ch < 3; ch++) begin
      prev2_row[c][ch] = prev1_row[c][ch];
      prev1_row[c][ch] = pv[ch];
    end
    c++;
    if (c >= s) begin
      c = 0;
      r++;
      if (r >= s) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d (beat %0d)", what, got, want, beats_checked);
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) begin
        predict_pixel({pix.in_red, pix.in_green, pix.in_blue});
        pixels_sent <= pixels_sent + 1;
      end
      if (!(pix.valid && !pix.ready)) begin
        if (pixels_pending.size() > 0 && !hold_pixels &&
            (quiet_stretch || $urandom_range(99) >= 20)) begin
          pixel_t p;
          p = pixels_pending.pop_front();
          pix.valid <= 1'b1;
          pix.in_red <= p.red;
          pix.in_green <= p.green;
          pix.in_blue <= p.blue;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (means_due.size() == 0) begin
          report_mismatch("unexpected beat row", res.out_row, -1);
        end else begin
          mean_t w;
          w = means_due.pop_front();
          if (res.out_red !== w.red) report_mismatch("red", res.out_red, w.red);
          if (res.out_green !== w.green) report_mismatch("green", res.out_green, w.green);
          if (res.out_blue !== w.blue) report_mismatch("blue", res.out_blue, w.blue);
          if (res.out_row !== w.row) report_mismatch("row", res.out_row, w.row);
          if (res.out_col !== w.col) report_mismatch("col", res.out_col, w.col);
          if (res.last_in_run !== w.last) report_mismatch("last", res.last_in_run, w.last);
        end
        beats_checked <= beats_checked + 1;
      end
      res.ready <= quiet_stretch || ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 400000) begin
      $display("timeout");
      $display("box_filter_3x3_edge_mean_top test failed");
      $finish;
    end
  end

  initial begin
    pix.valid = 1'b0;
    pix.in_red = '0;
    pix.in_green = '0;
    pix.in_blue = '0;
    res.ready = 1'b0;
  end

  task automatic drain();
    while (pixels_pending.size() > 0 || pix.valid || means_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_side(int unsigned s);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= s[SIDE_W-1:0];
    side_reg = s[SIDE_W-1:0];
    cur_row = 0;
    cur_col = 0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    case ($urandom_range(3))
      0: p = '1;
      1: p = '0;
      default: p = 48'({$urandom, $urandom});
    endcase
    return p;
  endfunction

  task automatic queue_frame(int unsigned count);
    for (int i = 0; i < count; i++) pixels_pending.push_back(rand_pixel());
  endtask

  initial begin
    side_reg = SIDE_RESET;
    cur_row = 0;
    cur_col = 0;
    for (int i = 0; i < 6; i++) for (int ch = 0; ch < 3; ch++) col_sums[i][ch] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed: reset side, partial row, then extremes and tiny sides
    for (int i = 0; i < 3; i++) pixels_pending.push_back('1);
    drain();
    set_side(1);
    pixels_pending.push_back('1);
    pixels_pending.push_back('0);
    drain();
    set_side(0);
    pixels_pending.push_back({16'hFFFF, 16'h0000, 16'hA5A5});
    drain();
    set_side(2);
    for (int i = 0; i < 4; i++) pixels_pending.push_back('1);
    drain();
    set_side(3);
    // mid-frame restart
    for (int i = 0; i < 4; i++) pixels_pending.push_back({16'h5A5A, 16'hFFFF, 16'h0001});
    drain();
    set_side(2047);
    for (int i = 0; i < 2; i++) pixels_pending.push_back('1);
    drain();
    // random frames, small sides mostly
    set_side(4);
    quiet_stretch = 1;
    queue_frame(16);
    drain();
    quiet_stretch = 0;
    repeat (6) begin
      int unsigned s;
      s = $urandom_range(2, 5);
      set_side(s);
      queue_frame(s * s * $urandom_range(1, 2));
      hold_pixels = 1;
      repeat ($urandom_range(3)) @(posedge clk);
      hold_pixels = 0;
      drain();
    end
    set_side(1024);
    queue_frame(12);
    drain();
    $display("covered %0d pixels and %0d result beats over sides 0..2047", pixels_sent,
             beats_checked);
    if (error_count == 0) $display("box_filter_3x3_edge_mean_top test passed");
    else $display("box_filter_3x3_edge_mean_top test failed");
    $finish;
  end

endmodule

/* files.f */
src/bf_pkg.sv
src/bf_if.sv
src/bf_linebuf.sv
src/bf_window.sv
src/bf_mean.sv
src/box_filter_3x3_edge_mean_top.sv
tb/sv/box_filter_3x3_edge_mean_top_test.sv
